// ===== rtl/lfu_pkg.sv =====
package lfu_pkg;

    // Geometry of the frame set
    localparam int FRAMES         = 4;
    localparam int COUNT_BITS     = 16;
    localparam int FRAME_BITS     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int PAGE_BITS      = 16;
    localparam int FAULT_BITS     = 32;
    localparam int FRAME_OUT_BITS = 2;

    typedef logic [FRAME_BITS-1:0] t_frame_idx;
    typedef logic [PAGE_BITS-1:0]  t_page;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [FAULT_BITS-1:0] t_fault;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } t_state;

    // Write request into the frame table
    typedef struct packed {
        logic       we;
        logic       clear;
        logic       hit;
        t_frame_idx idx;
        t_page      page;
    } t_tbl_wr;

    // Step control for the scan unit
    typedef struct packed {
        logic       step;
        logic       first;
        t_frame_idx idx;
    } t_scan_ctl;

    // Outcome of one full scan
    typedef struct packed {
        logic       found;
        t_frame_idx match_idx;
        t_frame_idx victim_idx;
        logic       victim_valid;
        t_page      victim_page;
    } t_scan_res;

endpackage

// ===== rtl/lfu_frame_table.sv =====
module lfu_frame_table
    import lfu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_frame_idx i_rd_idx,
    output logic       o_rd_valid,
    output t_page      o_rd_page,
    output t_count     o_rd_count,
    input  t_tbl_wr    i_wr
);

    logic [FRAMES-1:0] r_valid;
    t_page             r_page  [FRAMES];
    t_count            r_count [FRAMES];

    // Read the entry under scan
    assign o_rd_valid = r_valid[i_rd_idx];
    assign o_rd_page  = r_page[i_rd_idx];
    assign o_rd_count = r_count[i_rd_idx];

    // Track valid bits; clear all at end of run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.we) begin
            if (i_wr.clear) begin
                r_valid <= '0;
            end else begin
                r_valid[i_wr.idx] <= 1'b1;
            end
        end
    end

    // Bump count on hit, load page with count one on fill
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            if (i_wr.hit) begin
                if (r_count[i_wr.idx] != '1) begin
                    r_count[i_wr.idx] <= r_count[i_wr.idx] + t_count'(1);
                end
            end else begin
                r_page[i_wr.idx]  <= i_wr.page;
                r_count[i_wr.idx] <= t_count'(1);
            end
        end
    end

endmodule

// ===== rtl/lfu_scan_unit.sv =====
module lfu_scan_unit
    import lfu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_scan_ctl i_ctl,
    input  t_page     i_key,
    input  logic      i_valid,
    input  t_page     i_page,
    input  t_count    i_count,
    output t_scan_res o_res
);

    t_scan_res r_res;
    t_count    r_min;
    t_count    eff_count;
    logic      match;

    // Empty frames count as zero and never match
    assign eff_count = i_valid ? i_count : '0;
    assign match     = i_valid && (i_page == i_key);

    // Record first match and strict minimum, one frame per step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.found <= 1'b0;
        end else if (i_ctl.step) begin
            if (i_ctl.first) begin
                r_res.found <= match;
            end else if (match) begin
                r_res.found <= 1'b1;
            end
        end
        if (i_ctl.step) begin
            if (i_ctl.first || (match && !r_res.found)) begin
                r_res.match_idx <= i_ctl.idx;
            end
            if (i_ctl.first || (eff_count < r_min)) begin
                r_min                <= eff_count;
                r_res.victim_idx     <= i_ctl.idx;
                r_res.victim_valid   <= i_valid;
                r_res.victim_page    <= i_valid ? i_page : '0;
            end
        end
    end

    assign o_res = r_res;

endmodule

// ===== rtl/lfu_page_replacement.sv =====
// Channel  | handshake                  | payload
// ---------+----------------------------+------------------------------------------
// in       | i_in_valid / o_in_ready    | i_page, i_end_of_string
// out      | o_out_valid / i_out_ready  | o_hit, o_frame, o_evicted_valid,
//          |                            | o_evicted_page, o_fault_total, o_last
//
// Each item is accepted, then visits each frame in turn through the shared compare/minimum
// unit, and finally updates the table and loads the result.
// The result register frees the input side: the next item is taken while a result waits.
// The update step holds while the result register is still full and not taken.
// Reset (synchronous, active low) empties all frames and zeroes the fault total.
module lfu_page_replacement
    import lfu_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [PAGE_BITS-1:0]      i_page,
    input  logic                      i_end_of_string,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_hit,
    output logic [FRAME_OUT_BITS-1:0] o_frame,
    output logic                      o_evicted_valid,
    output logic [PAGE_BITS-1:0]      o_evicted_page,
    output logic [FAULT_BITS-1:0]     o_fault_total,
    output logic                      o_last
);

    t_state     r_state, n_state;
    t_frame_idx r_idx, n_idx;
    t_page      r_page;
    logic       r_eos;
    t_fault     r_fault, n_fault;

    logic                      r_out_valid, n_out_valid;
    logic                      r_hit;
    logic [FRAME_OUT_BITS-1:0] r_frame;
    logic                      r_ev_valid;
    t_page                     r_ev_page;
    t_fault                    r_fault_out;
    logic                      r_last;

    logic       accept;
    logic       upd_go;
    t_frame_idx use_idx;
    t_scan_ctl  scan_ctl;
    t_scan_res  scan_res;
    t_tbl_wr    tbl_wr;
    logic       rd_valid;
    t_page      rd_page;
    t_count     rd_count;

    lfu_frame_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_idx   (r_idx),
        .o_rd_valid (rd_valid),
        .o_rd_page  (rd_page),
        .o_rd_count (rd_count),
        .i_wr       (tbl_wr)
    );

    lfu_scan_unit u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_key   (r_page),
        .i_valid (rd_valid),
        .i_page  (rd_page),
        .i_count (rd_count),
        .o_res   (scan_res)
    );

    // Sequence: accept, scan each frame, update
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        accept   = 1'b0;
        upd_go   = 1'b0;
        scan_ctl = '{step: 1'b0, first: 1'b0, idx: r_idx};
        unique case (r_state)
            S_IDLE: begin
                accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_SCAN;
                    n_idx   = '0;
                end
            end
            S_SCAN: begin
                scan_ctl.step  = 1'b1;
                scan_ctl.first = (r_idx == '0);
                if (r_idx == t_frame_idx'(FRAMES - 1)) begin
                    n_state = S_UPDATE;
                end else begin
                    n_idx = r_idx + t_frame_idx'(1);
                end
            end
            S_UPDATE: begin
                upd_go = !r_out_valid || i_out_ready;
                if (upd_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Pick the frame used and the new fault total
    assign use_idx = scan_res.found ? scan_res.match_idx : scan_res.victim_idx;
    assign n_fault = (!scan_res.found && (r_fault != '1)) ? r_fault + t_fault'(1) : r_fault;

    assign tbl_wr = '{we: upd_go, clear: r_eos, hit: scan_res.found,
                      idx: use_idx, page: r_page};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_fault <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (upd_go) begin
                r_fault <= r_eos ? '0 : n_fault;
            end
        end
    end

    // Hold the accepted item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_page <= i_page;
            r_eos  <= i_end_of_string;
        end
    end

    // Result register
    assign n_out_valid = upd_go || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_go) begin
            r_hit       <= scan_res.found;
            r_frame     <= FRAME_OUT_BITS'(use_idx);
            r_ev_valid  <= !scan_res.found && scan_res.victim_valid;
            r_ev_page   <= (!scan_res.found && scan_res.victim_valid) ?
                           scan_res.victim_page : '0;
            r_fault_out <= n_fault;
            r_last      <= r_eos;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_hit;
    assign o_frame         = r_frame;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = r_ev_page;
    assign o_fault_total   = r_fault_out;
    assign o_last          = r_last;

    // An accepted item keeps the block busy for the scan
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again during scan");

    // A hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit) |-> (!o_evicted_valid && (o_evicted_page == '0)))
        else $error("eviction reported on hit");

    // A miss has always counted at least one fault
    a_miss_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_hit) |-> (o_fault_total != '0))
        else $error("miss with zero fault total");

endmodule
